FILE: sv/rrit_pkg.sv
// Shared types, command and status codes, and sequencer states for the round-robin table.
package rrit_pkg;

  localparam int DEF_CAPACITY  = 16;
  localparam int DEF_KEY_BITS  = 32;
  localparam int DEF_ADDR_BITS = 32;

  localparam int FIELD_BITS = 32;
  localparam int WIDE_BITS  = 64;
  localparam int ROT_BITS   = 32;
  localparam int BIT_CNT_W  = $clog2(ROT_BITS);

  localparam logic [1:0] CMD_ADD    = 2'd0;
  localparam logic [1:0] CMD_REMOVE = 2'd1;
  localparam logic [1:0] CMD_NEXT   = 2'd2;

  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_NOT_FOUND = 2'd1;
  localparam logic [1:0] STAT_EMPTY     = 2'd2;
  localparam logic [1:0] STAT_FULL      = 2'd3;

  typedef struct packed {
    logic [1:0]            cmd;
    logic [FIELD_BITS-1:0] key_id;
    logic [FIELD_BITS-1:0] entry_address;
  } in_word_t;

  typedef struct packed {
    logic [1:0]            status;
    logic [FIELD_BITS-1:0] picked_id;
    logic [FIELD_BITS-1:0] picked_address;
  } out_word_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ADD,
    S_SCAN_RD,
    S_SCAN_CMP,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_DROP,
    S_DIV,
    S_PICK_RD,
    S_PICK_DATA,
    S_FINISH
  } state_t;

endpackage

FILE: sv/round_robin_instance_table_top.sv
// Round-robin selector over a compacting table of id/address entries.
//
// Input channel (in_valid/in_ready/in_data) takes one command word: add an
// entry, remove the first entry with a matching id, or pick the next entry in
// rotation. Output channel (out_valid/out_ready/out_data) returns one word per
// command: status plus, for a successful pick, the entry's id and address.
// Commands run one at a time; in_ready is high only while the sequencer idles.
// Steps per command, counted from acceptance to the result register loading:
//   add: a write step (no write when full). unused code, or remove/next on an
//   empty table: straight to finish. remove: a read and a compare per entry
//   scanned, a read and a write per entry moved down, then a drop step on a hit.
//   next: the bit-serial remainder unit (one bit of the 32-bit rotation
//   counter per cycle), then the registered table read.
// The table sits in one RAM (registered read) shared by scan, shift and pick.
// Reset clears the entry count, rotation counter and output valid; table
// contents need no clearing since only slots below the count are read.
// A finished word waits in the output register while the next command is
// taken; the sequencer holds its result until that register frees up.
module round_robin_instance_table_top #(
  parameter int CAPACITY  = rrit_pkg::DEF_CAPACITY,
  parameter int KEY_BITS  = rrit_pkg::DEF_KEY_BITS,
  parameter int ADDR_BITS = rrit_pkg::DEF_ADDR_BITS
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  rrit_pkg::in_word_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output rrit_pkg::out_word_t out_data
);

  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int IDX_W  = $clog2(CAPACITY);
  localparam int WORD_W = KEY_BITS + ADDR_BITS;

  rrit_pkg::state_t state, state_next;

  logic [CNT_W-1:0]              entry_count;
  logic [rrit_pkg::ROT_BITS-1:0] rotation_counter;

  logic [KEY_BITS-1:0]            key_reg;
  logic [ADDR_BITS-1:0]           addr_reg;
  logic [CNT_W-1:0]               scan_idx;
  logic [CNT_W-1:0]               rem;
  logic [rrit_pkg::ROT_BITS-1:0]  div_shift;
  logic [rrit_pkg::BIT_CNT_W-1:0] bit_cnt;
  rrit_pkg::out_word_t            res;

  logic              wr_en;
  logic [IDX_W-1:0]  wr_addr;
  logic [WORD_W-1:0] wr_data;
  logic [IDX_W-1:0]  rd_addr;
  logic [WORD_W-1:0] rd_data;

  logic [KEY_BITS-1:0]  rd_id;
  logic [ADDR_BITS-1:0] rd_address;
  logic [rrit_pkg::WIDE_BITS-1:0] key_wide, addr_wide, id_out_wide, addr_out_wide;

  logic             full;
  logic             match;
  logic [CNT_W-1:0] scan_inc;
  logic             scan_more;
  logic             shift_more;
  logic [CNT_W:0]   trial;
  logic             trial_ge;
  logic [CNT_W-1:0] rem_step;
  logic [CNT_W-1:0] count_dec;
  logic             out_free;

  rrit_ram #(
    .WIDTH (WORD_W),
    .DEPTH (CAPACITY)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign key_wide      = rrit_pkg::WIDE_BITS'(in_data.key_id);
  assign addr_wide     = rrit_pkg::WIDE_BITS'(in_data.entry_address);
  assign rd_id         = rd_data[WORD_W-1:ADDR_BITS];
  assign rd_address    = rd_data[ADDR_BITS-1:0];
  assign id_out_wide   = rrit_pkg::WIDE_BITS'(rd_id);
  assign addr_out_wide = rrit_pkg::WIDE_BITS'(rd_address);

  assign full       = (entry_count == CNT_W'(CAPACITY));
  assign match      = (rd_id == key_reg);
  assign scan_inc   = scan_idx + 1'b1;
  assign scan_more  = (scan_inc < entry_count);
  assign shift_more = ({1'b0, scan_idx} + (CNT_W+1)'(2)) < {1'b0, entry_count};
  assign count_dec  = entry_count - 1'b1;
  assign out_free   = !out_valid || out_ready;

  // One restoring step of rotation_counter mod entry_count.
  assign trial    = {rem, div_shift[rrit_pkg::ROT_BITS-1]};
  assign trial_ge = (trial >= {1'b0, entry_count});
  assign rem_step = trial_ge ? CNT_W'(trial - {1'b0, entry_count}) : trial[CNT_W-1:0];

  assign in_ready = (state == rrit_pkg::S_IDLE) && !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rrit_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    wr_en      = 1'b0;
    wr_addr    = entry_count[IDX_W-1:0];
    wr_data    = {key_reg, addr_reg};
    rd_addr    = scan_idx[IDX_W-1:0];
    case (state)
      rrit_pkg::S_IDLE: begin
        if (in_valid) begin
          case (in_data.cmd)
            rrit_pkg::CMD_ADD:    state_next = rrit_pkg::S_ADD;
            rrit_pkg::CMD_REMOVE: state_next = (entry_count == '0) ? rrit_pkg::S_FINISH
                                                                   : rrit_pkg::S_SCAN_RD;
            rrit_pkg::CMD_NEXT:   state_next = (entry_count == '0) ? rrit_pkg::S_FINISH
                                                                   : rrit_pkg::S_DIV;
            default:              state_next = rrit_pkg::S_FINISH;
          endcase
        end
      end
      rrit_pkg::S_ADD: begin
        wr_en      = !full;
        state_next = rrit_pkg::S_FINISH;
      end
      rrit_pkg::S_SCAN_RD: begin
        state_next = rrit_pkg::S_SCAN_CMP;
      end
      rrit_pkg::S_SCAN_CMP: begin
        if (match) begin
          state_next = scan_more ? rrit_pkg::S_SHIFT_RD : rrit_pkg::S_DROP;
        end else begin
          state_next = scan_more ? rrit_pkg::S_SCAN_RD : rrit_pkg::S_FINISH;
        end
      end
      rrit_pkg::S_SHIFT_RD: begin
        rd_addr    = scan_inc[IDX_W-1:0];
        state_next = rrit_pkg::S_SHIFT_WR;
      end
      rrit_pkg::S_SHIFT_WR: begin
        // Move the entry above down into this slot.
        wr_en      = 1'b1;
        wr_addr    = scan_idx[IDX_W-1:0];
        wr_data    = rd_data;
        state_next = shift_more ? rrit_pkg::S_SHIFT_RD : rrit_pkg::S_DROP;
      end
      rrit_pkg::S_DROP: begin
        state_next = rrit_pkg::S_FINISH;
      end
      rrit_pkg::S_DIV: begin
        if (bit_cnt == '0) begin
          state_next = rrit_pkg::S_PICK_RD;
        end
      end
      rrit_pkg::S_PICK_RD: begin
        rd_addr    = rem[IDX_W-1:0];
        state_next = rrit_pkg::S_PICK_DATA;
      end
      rrit_pkg::S_PICK_DATA: begin
        state_next = rrit_pkg::S_FINISH;
      end
      rrit_pkg::S_FINISH: begin
        if (out_free) begin
          state_next = rrit_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = rrit_pkg::S_IDLE;
      end
    endcase
  end

  // Control state: count, rotation counter, output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count      <= '0;
      rotation_counter <= '0;
      out_valid        <= 1'b0;
    end else begin
      if (state == rrit_pkg::S_FINISH && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        rrit_pkg::S_ADD: begin
          if (!full) begin
            entry_count <= entry_count + 1'b1;
          end
        end
        rrit_pkg::S_DROP: begin
          entry_count <= count_dec;
          if (rotation_counter >= rrit_pkg::ROT_BITS'(count_dec)) begin
            rotation_counter <= '0;
          end
        end
        rrit_pkg::S_PICK_DATA: begin
          rotation_counter <= rotation_counter + 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  // Working registers and the output word.
  always_ff @(posedge clk) begin
    case (state)
      rrit_pkg::S_IDLE: begin
        if (in_valid) begin
          key_reg            <= key_wide[KEY_BITS-1:0];
          addr_reg           <= addr_wide[ADDR_BITS-1:0];
          scan_idx           <= '0;
          rem                <= '0;
          div_shift          <= rotation_counter;
          bit_cnt            <= rrit_pkg::BIT_CNT_W'(rrit_pkg::ROT_BITS - 1);
          res.picked_id      <= '0;
          res.picked_address <= '0;
          if (entry_count == '0 && in_data.cmd == rrit_pkg::CMD_REMOVE) begin
            res.status <= rrit_pkg::STAT_NOT_FOUND;
          end else if (entry_count == '0 && in_data.cmd == rrit_pkg::CMD_NEXT) begin
            res.status <= rrit_pkg::STAT_EMPTY;
          end else begin
            res.status <= rrit_pkg::STAT_OK;
          end
        end
      end
      rrit_pkg::S_ADD: begin
        if (full) begin
          res.status <= rrit_pkg::STAT_FULL;
        end
      end
      rrit_pkg::S_SCAN_CMP: begin
        if (!match) begin
          scan_idx <= scan_inc;
          if (!scan_more) begin
            res.status <= rrit_pkg::STAT_NOT_FOUND;
          end
        end
      end
      rrit_pkg::S_SHIFT_WR: begin
        scan_idx <= scan_inc;
      end
      rrit_pkg::S_DIV: begin
        rem       <= rem_step;
        div_shift <= div_shift << 1;
        bit_cnt   <= bit_cnt - 1'b1;
      end
      rrit_pkg::S_PICK_DATA: begin
        res.picked_id      <= id_out_wide[rrit_pkg::FIELD_BITS-1:0];
        res.picked_address <= addr_out_wide[rrit_pkg::FIELD_BITS-1:0];
      end
      rrit_pkg::S_FINISH: begin
        if (out_free) begin
          out_data <= res;
        end
      end
      default: begin
      end
    endcase
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    entry_count <= CNT_W'(CAPACITY))
    else $error("entry count exceeds capacity");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("took a second word while busy");

  a_write_source: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (state == rrit_pkg::S_ADD || state == rrit_pkg::S_SHIFT_WR))
    else $error("table write outside add or shift");

  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    state == rrit_pkg::S_DIV |-> (rem < entry_count))
    else $error("remainder not below entry count");

endmodule

FILE: sv/rrit_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module rrit_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule
